// ----- rtl/stfc_pkg.sv -----
// Package for the stereo to five-channel crossover: widths, coefficients,
// register indexes and fixed-point helpers. No dependencies.
package stfc_pkg;

    localparam int SAMPLE_BITS_DEF = 32;
    localparam int GUARD_BITS_DEF  = 8;
    localparam int CFG_IDX_BITS    = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MODE       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_IN_GAIN    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BASS_GAIN  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_BAND_GAIN  = 3'd4;

    localparam logic signed [31:0] IN_GAIN_RST    = 32'sd2147483647;
    localparam logic signed [31:0] BASS_GAIN_RST  = 32'sd727662286;
    localparam logic signed [31:0] BAND_GAIN_RST  = 32'sd1386531899;

    // biquad coefficients, half scale, order b0 b1 b2 a1 a2
    function automatic logic signed [31:0] coef(input logic hp, input logic [2:0] k);
        logic signed [31:0] c;
        c = '0;
        if (hp) begin
            case (k)
                3'd0:    c = 32'sd812937147;
                3'd1:    c = -32'sd1625874295;
                3'd2:    c = 32'sd812937147;
                3'd3:    c = -32'sd1561482161;
                3'd4:    c = 32'sd616394288;
                default: c = '0;
            endcase
        end else begin
            case (k)
                3'd0:    c = 32'sd166484771;
                3'd1:    c = 32'sd332969542;
                3'd2:    c = 32'sd166484771;
                3'd3:    c = -32'sd665939085;
                3'd4:    c = 32'sd258136345;
                default: c = '0;
            endcase
        end
        return c;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)       r = 32'sh7fffffff;
        else if (v < -64'sd2147483648) r = 32'sh80000000;
        else                           r = v[31:0];
        return r;
    endfunction

    typedef struct packed {
        logic start;
    } lane_ctl_t;

endpackage

// ----- rtl/stereo_to_five_channel_crossover.sv -----
// Stereo to five-channel crossover top level: config registers, two lanes
// (left, right) and the merge stage. Depends on stfc_pkg, stfc_lane, stfc_merge.
// Each enabled item runs 18 products a lane, each issued and then resolved, and then
//   loads the output register; a disabled item loads zeros directly. A new item is
//   taken only once the lanes are idle; disabled items one per cycle while the output
//   register is free. Reset is async active low; history cleared, registers default.
module stereo_to_five_channel_crossover #(
    parameter int SAMPLE_BITS = stfc_pkg::SAMPLE_BITS_DEF,
    parameter int GUARD_BITS  = stfc_pkg::GUARD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [63:0]                     s_axis_tdata, // left_in, right_in
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // left_surround_out, left_out, bass_out, right_surround_out, right_out
    output logic [159:0]                    m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [stfc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [31:0]                     cfg_data
);
    import stfc_pkg::*;

    logic               enable_reg, mode_reg;
    logic signed [31:0] in_gain_reg, bass_gain_reg, band_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b1;
            mode_reg       <= 1'b0;
            in_gain_reg    <= IN_GAIN_RST;
            bass_gain_reg  <= BASS_GAIN_RST;
            band_gain_reg  <= BAND_GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLE:     enable_reg     <= cfg_data[0];
                REG_MODE:       mode_reg       <= cfg_data[0];
                REG_IN_GAIN:    in_gain_reg    <= cfg_data;
                REG_BASS_GAIN:  bass_gain_reg  <= cfg_data;
                REG_BAND_GAIN:  band_gain_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // one item in the lanes at a time; busy until merge has loaded the result.
    // An enabled transaction may start while the previous result still waits;
    // a finished lane result is held (pend_reg) until the output register frees.
    logic busy_reg, pend_reg;
    logic acc_in, full, ldone, rdone, out_free, lload, zload, load;
    lane_ctl_t ctl;

    assign out_free      = !full || m_axis_tready;
    assign s_axis_tready = !busy_reg && (enable_reg || out_free);
    assign acc_in        = s_axis_tvalid && s_axis_tready;
    assign ctl.start     = acc_in && enable_reg;
    assign zload         = acc_in && !enable_reg;
    assign lload         = (ldone || pend_reg) && out_free;
    assign load          = lload || zload;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (ctl.start)
            busy_reg <= 1'b1;
        else if (lload)
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else if (lload)
            pend_reg <= 1'b0;
        else if (ldone)
            pend_reg <= 1'b1;
    end

    logic signed [31:0] ls, lband, lbass, rs, rband, rbass;

    stfc_lane #(.SAMPLE_BITS(SAMPLE_BITS), .GUARD_BITS(GUARD_BITS)) u_left (
        .clk(clk), .rst_n(rst_n), .ctl_in(ctl), .done(ldone),
        .sample(s_axis_tdata[31:0]), .in_gain(in_gain_reg),
        .bass_gain(bass_gain_reg), .band_gain(band_gain_reg),
        .surround(ls), .band(lband), .bass(lbass)
    );

    stfc_lane #(.SAMPLE_BITS(SAMPLE_BITS), .GUARD_BITS(GUARD_BITS)) u_right (
        .clk(clk), .rst_n(rst_n), .ctl_in(ctl), .done(rdone),
        .sample(s_axis_tdata[63:32]), .in_gain(in_gain_reg),
        .bass_gain(bass_gain_reg), .band_gain(band_gain_reg),
        .surround(rs), .band(rband), .bass(rbass)
    );

    // note: the lanes capture tdata at the accept edge
    stfc_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
        .clk(clk), .rst_n(rst_n), .load(load), .zero(zload), .mode(mode_reg),
        .ls(ls), .lband(lband), .lbass(lbass), .rs(rs), .rband(rband), .rbass(rbass),
        .take(m_axis_tready), .full(full), .data(m_axis_tdata)
    );

    assign m_axis_tvalid = full;

    // lanes run in lock step
    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n) ldone == rdone)
        else $error("lanes out of step");
    // no new transaction while work is in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        acc_in |-> !busy_reg) else $error("accept while busy");
    // a lane only finishes while busy
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ldone |-> busy_reg) else $error("spurious lane done");
    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> out_free) else $error("result overwritten");
endmodule

// ----- rtl/stfc_lane.sv -----
// One channel lane: input gain, HP / band LP / bass LP biquads and gains
// on a single shared 32x32 multiplier. Depends on stfc_pkg.
module stfc_lane #(
    parameter int SAMPLE_BITS = stfc_pkg::SAMPLE_BITS_DEF,
    parameter int GUARD_BITS  = stfc_pkg::GUARD_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  stfc_pkg::lane_ctl_t      ctl_in,
    output logic                     done,
    input  logic signed [31:0]       sample,
    input  logic signed [31:0]       in_gain,
    input  logic signed [31:0]       bass_gain,
    input  logic signed [31:0]       band_gain,
    output logic signed [31:0]       surround,
    output logic signed [31:0]       band,
    output logic signed [31:0]       bass
);
    import stfc_pkg::*;

    localparam int ACC_BITS = 32 + GUARD_BITS;
    localparam logic [31:0] KEEP = ~((32'd1 << (32 - SAMPLE_BITS)) - 32'd1);

    // op codes for the sequencer
    typedef enum logic [3:0] {
        OP_GAIN  = 4'd0,
        OP_HP    = 4'd1,
        OP_BASS  = 4'd2,
        OP_BASSG = 4'd3,
        OP_BAND  = 4'd4,
        OP_BANDG = 4'd5,
        OP_DONE  = 4'd6
    } op_t;

    op_t                    op_reg;
    logic [2:0]             k_reg;
    logic                   busy_reg;
    logic                   mv_reg;     // product register valid
    logic                   done_reg;   // results settled, one-cycle pulse
    logic signed [63:0]     prod_reg;
    logic [2:0]             pk_reg;
    op_t                    pop_reg;
    logic signed [ACC_BITS-1:0] acc_reg;
    logic signed [31:0]     x_reg;      // raw sample, then gained sample
    logic signed [31:0]     hist_reg [12]; // per section x1 x2 y1 y2
    logic signed [31:0]     surround_reg, band_reg, bass_reg, lpy_reg;

    function automatic logic signed [31:0] quant(input logic signed [31:0] v);
        return v & KEEP;
    endfunction

    logic [1:0]         sec;
    logic [1:0]         kidx;
    logic               hp_sel;
    logic signed [31:0] vin, ma, mb, fin;
    always_comb
    begin
        sec = 2'd0;
        case (op_reg)
            OP_HP:   sec = 2'd0;
            OP_BASS: sec = 2'd2;
            default: sec = 2'd1;
        endcase
        // k = 1..4 selects x1 x2 y1 y2
        kidx = k_reg[1:0] - 2'd1;
        hp_sel = (op_reg == OP_HP);
        vin = (op_reg == OP_BAND) ? surround_reg : x_reg;
        ma = '0;
        mb = '0;
        case (op_reg)
            OP_GAIN:  begin ma = x_reg;   mb = in_gain;    end
            OP_BASSG: begin ma = lpy_reg; mb = bass_gain;  end
            OP_BANDG: begin ma = lpy_reg; mb = band_gain;  end
            OP_HP, OP_BASS, OP_BAND:
            begin
                ma = coef(hp_sel, k_reg);
                mb = (k_reg == 3'd0) ? vin : hist_reg[{sec, kidx}];
            end
            default: ;
        endcase
    end

    logic last_k;
    assign last_k = (op_reg == OP_GAIN || op_reg == OP_BASSG || op_reg == OP_BANDG)
                    || k_reg == 3'd4;

    logic signed [63:0]         term;
    logic signed [ACC_BITS-1:0] acc_next;
    logic signed [31:0]         y;
    always_comb
    begin
        term = prod_reg >>> 30;
        if (pk_reg == 3'd0)      acc_next = term[ACC_BITS-1:0];
        else if (pk_reg >= 3'd3) acc_next = acc_reg - term[ACC_BITS-1:0];
        else                     acc_next = acc_reg + term[ACC_BITS-1:0];
        y   = quant(sat32(64'(acc_next)));
        fin = quant(sat32(prod_reg >>> 31));
    end

    logic [1:0] psec;
    always_comb
    begin
        psec = 2'd1;
        case (pop_reg)
            OP_HP:   psec = 2'd0;
            OP_BASS: psec = 2'd2;
            default: psec = 2'd1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mv_reg   <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_DONE;
            k_reg    <= '0;
            for (int i = 0; i < 12; i++) hist_reg[i] <= '0;
        end
        else
        begin
            done_reg <= mv_reg && pop_reg == OP_BANDG;
            if (ctl_in.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= OP_GAIN;
                k_reg    <= '0;
                x_reg    <= sample;
            end
            else if (busy_reg && !mv_reg)
            begin
                // issue one product, then wait for it to resolve
                mv_reg  <= 1'b1;
                prod_reg <= ma * mb;
                pk_reg  <= k_reg;
                pop_reg <= op_reg;
                if (last_k)
                begin
                    k_reg <= '0;
                    case (op_reg)
                        OP_GAIN:  op_reg <= OP_HP;
                        OP_HP:    op_reg <= OP_BASS;
                        OP_BASS:  op_reg <= OP_BASSG;
                        OP_BASSG: op_reg <= OP_BAND;
                        OP_BAND:  op_reg <= OP_BANDG;
                        default:  op_reg <= OP_DONE;
                    endcase
                end
                else
                    k_reg <= k_reg + 3'd1;
            end
            else if (mv_reg)
            begin
                mv_reg <= 1'b0;
                case (pop_reg)
                    OP_GAIN:  x_reg <= fin;
                    OP_BASSG: bass_reg <= fin;
                    OP_BANDG:
                    begin
                        band_reg <= fin;
                        busy_reg <= 1'b0;
                    end
                    OP_HP, OP_BASS, OP_BAND:
                    begin
                        acc_reg <= acc_next;
                        if (pk_reg == 3'd4)
                        begin
                            hist_reg[{psec, 2'b01}] <= hist_reg[{psec, 2'b00}];
                            hist_reg[{psec, 2'b00}] <= (pop_reg == OP_BAND) ? surround_reg : x_reg;
                            hist_reg[{psec, 2'b11}] <= hist_reg[{psec, 2'b10}];
                            hist_reg[{psec, 2'b10}] <= y;
                            if (pop_reg == OP_HP) surround_reg <= y;
                            else lpy_reg <= y;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign done     = done_reg;
    assign surround = surround_reg;
    assign band     = band_reg;
    assign bass     = bass_reg;
endmodule

// ----- rtl/stfc_merge.sv -----
// Merge stage: sums band and bass per side, applies mode and enable masks
// and holds the result transaction. Depends on stfc_pkg.
module stfc_merge #(
    parameter int SAMPLE_BITS = stfc_pkg::SAMPLE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic               zero,
    input  logic               mode,
    input  logic signed [31:0] ls, lband, lbass, rs, rband, rbass,
    input  logic               take,
    output logic               full,
    output logic [159:0]       data
);
    import stfc_pkg::*;
    localparam logic [31:0] KEEP = ~((32'd1 << (32 - SAMPLE_BITS)) - 32'd1);

    logic               full_reg;
    logic [159:0]       data_reg;
    logic signed [31:0] lo, ro;
    logic [159:0]       data_next;

    always_comb
    begin
        lo = sat32(64'(lband) + 64'(lbass)) & KEEP;
        ro = sat32(64'(rband) + 64'(rbass)) & KEEP;
        data_next = {ro, mode ? rs : 32'd0, mode ? lbass : 32'd0, lo, mode ? ls : 32'd0};
        if (zero) data_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else if (load)
            full_reg <= 1'b1;
        else if (take)
            full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load) data_reg <= data_next;
    end

    assign full = full_reg;
    assign data = data_reg;
endmodule

// ----- verif/stereo_to_five_channel_crossover_tb.sv -----
// Self-checking bench for the stereo to five-channel crossover: a bit-exact
// predictor of the six biquad sections, directed and random sample streams.
// Depends on stfc_pkg and the stereo_to_five_channel_crossover RTL.
module stereo_to_five_channel_crossover_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import stfc_pkg::*;

    localparam int  ACC_W     = 32 + GUARD_BITS_DEF;
    localparam int  CYC_LIMIT = 2000000;
    localparam int  LATENCY   = 40;

    // indexes past the register list, expected to be ignored
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic signed [31:0] right_out;
        logic signed [31:0] right_surround;
        logic signed [31:0] bass;
        logic signed [31:0] left_out;
        logic signed [31:0] left_surround;
    } mix_t;

    typedef logic signed [31:0] coef_row_t [5];

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;
    logic         cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [31:0]  cfg_data;

    // predictor copy of the registers and per-section history
    logic               en_q;
    logic               mode_q;
    logic signed [31:0] in_gain_q;
    logic signed [31:0] bass_gain_q;
    logic signed [31:0] band_gain_q;
    logic signed [31:0] hist [6][4];

    mix_t    mix_expected [$];
    int      mismatches;
    int      mixes_seen;
    longint  cycles;
    bit      stall_out;   // forces the receiver to hold off
    bit      busy_out;    // random receiver gaps enabled

    stereo_to_five_channel_crossover DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // left_in, right_in
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // ls, left, bass, rs, right
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1; #10;
        clk = 1'b0; #10;
    end

    // -------- predictor ------------------------------------------------
    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)  return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Q1.31 multiply, floor then saturate; -1 * -1 clips to full positive
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return clip32(p >>> 31);
    endfunction

    function automatic coef_row_t coefs_for(input bit hp);
        coef_row_t c;
        if (hp) c = '{32'sd812937147, -32'sd1625874295, 32'sd812937147,
                      -32'sd1561482161, 32'sd616394288};
        else    c = '{32'sd166484771, 32'sd332969542, 32'sd166484771,
                      -32'sd665939085, 32'sd258136345};
        return c;
    endfunction

    // one section; the half-scale coefficients give doubled products (>>>30),
    // the sum wraps at the guard width before the final clip
    function automatic logic signed [31:0] run_section(input int sec,
                                                       input logic signed [31:0] x,
                                                       input bit hp);
        coef_row_t          c;
        logic signed [ACC_W-1:0] acc;
        logic signed [63:0] t [5];
        logic signed [31:0] y;
        c = coefs_for(hp);
        t[0] = (64'(c[0]) * 64'(x)) >>> 30;
        t[1] = (64'(c[1]) * 64'(hist[sec][0])) >>> 30;
        t[2] = (64'(c[2]) * 64'(hist[sec][1])) >>> 30;
        t[3] = (64'(c[3]) * 64'(hist[sec][2])) >>> 30;
        t[4] = (64'(c[4]) * 64'(hist[sec][3])) >>> 30;
        acc = ACC_W'(t[0] + t[1] + t[2] - t[3] - t[4]);
        y = clip32(64'(acc));
        hist[sec][1] = hist[sec][0];
        hist[sec][0] = x;
        hist[sec][3] = hist[sec][2];
        hist[sec][2] = y;
        return y;
    endfunction

    function automatic mix_t crossover_mix(input logic signed [31:0] li,
                                           input logic signed [31:0] ri);
        mix_t m;
        logic signed [31:0] l, r, ls, lbass, lband, rs, rband, rbass;
        m = '0;
        if (!en_q) return m;
        l = qmul(li, in_gain_q);
        r = qmul(ri, in_gain_q);
        ls    = run_section(0, l, 1'b1);
        lbass = qmul(run_section(2, l, 1'b0), bass_gain_q);
        lband = qmul(run_section(1, ls, 1'b0), band_gain_q);
        rs    = run_section(3, r, 1'b1);
        rband = qmul(run_section(4, rs, 1'b0), band_gain_q);
        rbass = qmul(run_section(5, r, 1'b0), bass_gain_q);
        m.left_out  = clip32(64'(lband) + 64'(lbass));
        m.right_out = clip32(64'(rband) + 64'(rbass));
        if (mode_q)
        begin
            m.left_surround  = ls;
            m.bass           = lbass;
            m.right_surround = rs;
        end
        return m;
    endfunction

    // -------- checking -------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH mix %0d %s: got %h expected %h", mixes_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : mix_checker
        mix_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (mix_expected.size() == 0)
                report_mismatch("unexpected transaction", got.left_out, 32'h0);
            else
            begin
                want = mix_expected.pop_front();
                if (got.left_surround !== want.left_surround)
                    report_mismatch("left_surround_out", got.left_surround, want.left_surround);
                if (got.left_out !== want.left_out)
                    report_mismatch("left_out", got.left_out, want.left_out);
                if (got.bass !== want.bass)
                    report_mismatch("bass_out", got.bass, want.bass);
                if (got.right_surround !== want.right_surround)
                    report_mismatch("right_surround_out", got.right_surround,
                                    want.right_surround);
                if (got.right_out !== want.right_out)
                    report_mismatch("right_out", got.right_out, want.right_out);
            end
            mixes_seen++;
        end
    end

    // receiver: random gaps, mostly short, occasionally long; forced stall wins
    always @(posedge clk)
    begin : receiver
        int gap;
        if (stall_out || (busy_out && ($urandom_range(0, 3) == 0)))
        begin
            m_axis_tready <= 1'b0;
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120)
                                                : $urandom_range(0, 3);
            repeat (gap) @(posedge clk);
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : watchdog
        cycles++;
        if (cycles > CYC_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("stereo_to_five_channel_crossover test failed");
            $finish;
        end
    end

    // -------- stimulus -------------------------------------------------
    // send one stereo pair; tvalid stays high for a following pair sent at once,
    // idle_input drops it. Sender gaps are optional.
    task automatic send_pair(input logic [31:0] li, input logic [31:0] ri,
                             input bit gaps);
        int gap;
        gap = 0;
        if (gaps && ($urandom_range(0, 2) == 0))
            gap = ($urandom_range(0, 24) == 0) ? $urandom_range(40, 200)
                                                : $urandom_range(1, 4);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ri, li};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        mix_expected.push_back(crossover_mix(li, ri));
    endtask

    task automatic idle_input();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain_mixes();
        idle_input();
        while (mix_expected.size() != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // register write while idle; mirrors the register semantics
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_ENABLE:     en_q        = val[0];
            REG_MODE:       mode_q      = val[0];
            REG_IN_GAIN:    in_gain_q   = val;
            REG_BASS_GAIN:  bass_gain_q = val;
            REG_BAND_GAIN:  band_gain_q = val;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return $urandom_range(0, 65535) - 32768;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed_extremes();
        write_reg(REG_MODE, 32'd1);
        send_pair(32'h0, 32'h0, 0);
        send_pair(32'h7fffffff, 32'h80000000, 0);
        send_pair(32'h7fffffff, 32'h7fffffff, 0);
        send_pair(32'h80000000, 32'h80000000, 0);
        send_pair(32'h80000000, 32'h7fffffff, 0);
        send_pair(32'h00000001, 32'hffffffff, 0);
        send_pair(32'h55555555, 32'haaaaaaaa, 0);
        drain_mixes();
        // -1 * -1 clips at the input gain; full swings push the guard bits
        write_reg(REG_IN_GAIN, 32'h80000000);
        write_reg(REG_BASS_GAIN, 32'h80000000);
        write_reg(REG_BAND_GAIN, 32'h80000000);
        repeat (4) send_pair(32'h80000000, 32'h80000000, 0);
        repeat (4) send_pair(32'h7fffffff, 32'h80000000, 0);
        drain_mixes();
        // stereo mode zeroes surrounds and bass, history keeps running
        write_reg(REG_MODE, 32'hfffffffe);
        write_reg(REG_BASS_GAIN, 32'h7fffffff);
        write_reg(REG_BAND_GAIN, 32'h7fffffff);
        send_pair(32'h40000000, 32'hc0000000, 0);
        send_pair(32'h7fffffff, 32'h80000000, 0);
        drain_mixes();
        // disabled: zero outputs, history held; upper register bits ignored
        write_reg(REG_ENABLE, 32'hfffffffe);
        send_pair(32'h12345678, 32'h9abcdef0, 0);
        send_pair(32'h7fffffff, 32'h80000000, 0);
        drain_mixes();
        write_reg(REG_ENABLE, 32'h00000003);
        write_reg(REG_SPARE_LO, 32'h0);   // unused indexes are ignored
        write_reg(REG_SPARE_HI, 32'hffffffff);
        send_pair(32'h0, 32'h0, 0);
        drain_mixes();
    endtask

    // phases of random samples under random register settings
    task automatic test_random_settings();
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(REG_ENABLE, ($urandom_range(0, 4) != 0) ? $urandom : 32'h1);
            write_reg(REG_MODE, $urandom);
            case (ph % 4)
                0: write_reg(REG_IN_GAIN, 32'h7fffffff);
                1: write_reg(REG_IN_GAIN, 32'h80000000);
                default: write_reg(REG_IN_GAIN, $urandom);
            endcase
            write_reg(REG_BASS_GAIN, (ph == 3) ? 32'h80000000 : $urandom);
            write_reg(REG_BAND_GAIN, (ph == 5) ? 32'h7fffffff : $urandom);
            repeat (100) send_pair(rand_sample(), rand_sample(), ph != 0);
            drain_mixes();
        end
    endtask

    // receiver holds off while the sender keeps offering pairs
    task automatic test_backpressure();
        write_reg(REG_ENABLE, 32'h1);
        write_reg(REG_MODE, 32'h1);
        fork
            begin
                stall_out = 1'b1;
                repeat (600) @(posedge clk);
                stall_out = 1'b0;
            end
            begin
                repeat (40) send_pair(rand_sample(), rand_sample(), 0);
                idle_input();
            end
        join
        drain_mixes();
        // sender waits for every result before each further pair
        repeat (20)
        begin
            send_pair(rand_sample(), rand_sample(), 1);
            drain_mixes();
        end
        write_reg(REG_ENABLE, 32'h0);
        repeat (40) send_pair(rand_sample(), rand_sample(), 1);
        drain_mixes();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        mismatches    = 0;
        mixes_seen    = 0;
        cycles        = 0;
        stall_out     = 1'b0;
        busy_out      = 1'b0;
        en_q          = 1'b1;
        mode_q        = 1'b0;
        in_gain_q     = IN_GAIN_RST;
        bass_gain_q   = BASS_GAIN_RST;
        band_gain_q   = BAND_GAIN_RST;
        foreach (hist[i, j]) hist[i][j] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults first: stereo mode, full input gain
        repeat (3) send_pair(rand_sample(), rand_sample(), 0);
        drain_mixes();
        test_directed_extremes();
        busy_out = 1'b1;
        test_random_settings();
        test_backpressure();
        drain_mixes();

        $display("covered %0d mixes over directed extremes, random gains and modes,",
                 mixes_seen);
        $display("disabled stretches, a long output stall and paced sending");
        if (mismatches == 0)
            $display("stereo_to_five_channel_crossover test passed");
        else
            $display("stereo_to_five_channel_crossover test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/stfc_pkg.sv
rtl/stfc_lane.sv
rtl/stfc_merge.sv
rtl/stereo_to_five_channel_crossover.sv
verif/stereo_to_five_channel_crossover_tb.sv
